// File: src/cpfc_pkg.sv
package cpfc_pkg;

   localparam int ByteWidth = 8;
   localparam int WordWidth = 32;
   localparam int FormatWidth = 4;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [FormatWidth-1:0] format_type;

   // pixel format codes
   localparam format_type FMT_R8     = 4'd0;
   localparam format_type FMT_R16    = 4'd1;
   localparam format_type FMT_XRGB   = 4'd2;
   localparam format_type FMT_XBGR   = 4'd3;
   localparam format_type FMT_ARGB   = 4'd4;
   localparam format_type FMT_YUV420 = 4'd5;
   localparam format_type FMT_RGB888 = 4'd6;
   localparam format_type FMT_BGR888 = 4'd7;
   localparam format_type FMT_YUYV   = 4'd8;

   localparam byte_type OPAQUE_ALPHA = 8'hff;

   // BT.601 integer coefficients, scaled by 256
   localparam int ProdWidth = 18;
   typedef logic signed [ProdWidth-1:0] prod_type;
   localparam prod_type COEF_RV = 18'sd359;
   localparam prod_type COEF_GU = 18'sd88;
   localparam prod_type COEF_GV = 18'sd183;
   localparam prod_type COEF_BU = 18'sd454;
   localparam prod_type CHROMA_OFFSET = 18'sd128;
   localparam prod_type CHANNEL_MAX = 18'sd255;

   function automatic byte_type clamp_channel(input prod_type x);
      byte_type r;
      if (x < 0) begin
         r = '0;
      end else if (x > CHANNEL_MAX) begin
         r = OPAQUE_ALPHA;
      end else begin
         r = x[ByteWidth-1:0];
      end
      return r;
   endfunction

endpackage

// File: src/camera_pixel_format_converter.sv
// Converts camera pixel words to RGBA, one word per clock: a word is taken
// into an input register and its pixel is then written to the result
// register once that is free, so with the result side ready the block
// sustains one word per cycle. YUYV words hold the input register until
// both of their pixels are written; words in an unknown format are
// dropped without a result. The format register is written through
// csr_write_enable/csr_write_data and must only change while idle.
module camera_pixel_format_converter import cpfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  format_type           csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WordWidth-1:0] req_source_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output byte_type             rsp_red,
   output byte_type             rsp_green,
   output byte_type             rsp_blue,
   output byte_type             rsp_alpha,
   output logic                 rsp_last_pixel
);

   format_type fmt_ff, fmt_in;
   logic a_valid_ff, a_valid_in;
   logic a_second_ff, a_second_in;
   logic [WordWidth-1:0] a_word_ff, a_word_in;
   logic o_valid_ff, o_valid_in;
   byte_type o_red_ff, o_red_in;
   byte_type o_green_ff, o_green_in;
   byte_type o_blue_ff, o_blue_in;
   byte_type o_alpha_ff, o_alpha_in;
   logic o_last_ff, o_last_in;

   byte_type b0, b1, b2, b3;
   byte_type yuv_y, yuv_v;
   byte_type yuv_red, yuv_green, yuv_blue;
   logic is_yuyv, is_known, out_free, emit, a_done, accept;

   assign b0 = a_word_ff[7:0];
   assign b1 = a_word_ff[15:8];
   assign b2 = a_word_ff[23:16];
   assign b3 = a_word_ff[31:24];

   assign is_yuyv  = (fmt_ff == FMT_YUYV);
   assign is_known = (fmt_ff <= FMT_YUYV);
   assign out_free = !o_valid_ff || rsp_ready;
   assign emit     = a_valid_ff && is_known && out_free;
   // unknown formats retire the word without a transfer on the result side
   assign a_done   = a_valid_ff && (!is_known || (out_free && (!is_yuyv || a_second_ff)));
   assign req_ready = !a_valid_ff || a_done;
   assign accept    = req_valid && req_ready;

   assign yuv_y = (is_yuyv && a_second_ff) ? b2 : b0;
   assign yuv_v = is_yuyv ? b3 : b2;

   cpfc_yuv u_yuv (
      .luma     (yuv_y),
      .chroma_u (b1),
      .chroma_v (yuv_v),
      .red      (yuv_red),
      .green    (yuv_green),
      .blue     (yuv_blue)
   );

   always_comb begin
      o_alpha_in = OPAQUE_ALPHA;
      o_last_in  = 1'b1;
      unique case (fmt_ff) inside
         FMT_R8: begin
            o_red_in = b0; o_green_in = b0; o_blue_in = b0;
         end
         FMT_R16: begin
            o_red_in = b1; o_green_in = b1; o_blue_in = b1;
         end
         FMT_XRGB, FMT_BGR888: begin
            o_red_in = b2; o_green_in = b1; o_blue_in = b0;
         end
         FMT_ARGB: begin
            o_red_in = b2; o_green_in = b1; o_blue_in = b0;
            o_alpha_in = b3;
         end
         FMT_XBGR, FMT_RGB888: begin
            o_red_in = b0; o_green_in = b1; o_blue_in = b2;
         end
         FMT_YUV420: begin
            o_red_in = yuv_red; o_green_in = yuv_green; o_blue_in = yuv_blue;
         end
         FMT_YUYV: begin
            o_red_in = yuv_red; o_green_in = yuv_green; o_blue_in = yuv_blue;
            o_last_in = a_second_ff;
         end
         default: begin
            o_red_in = '0; o_green_in = '0; o_blue_in = '0;
         end
      endcase
   end

   always_comb begin
      fmt_in = csr_write_enable ? csr_write_data : fmt_ff;
      a_word_in = accept ? req_source_word : a_word_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_done) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
      if (accept) begin
         a_second_in = 1'b0;
      end else if (emit && is_yuyv) begin
         a_second_in = 1'b1;
      end else begin
         a_second_in = a_second_ff;
      end
      if (emit) begin
         o_valid_in = 1'b1;
      end else if (rsp_ready) begin
         o_valid_in = 1'b0;
      end else begin
         o_valid_in = o_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff      <= FMT_R8;
         a_valid_ff  <= 1'b0;
         a_second_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         fmt_ff      <= fmt_in;
         a_valid_ff  <= a_valid_in;
         a_second_ff <= a_second_in;
         o_valid_ff  <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_word_ff <= a_word_in;
      if (emit) begin
         o_red_ff   <= o_red_in;
         o_green_ff <= o_green_in;
         o_blue_ff  <= o_blue_in;
         o_alpha_ff <= o_alpha_in;
         o_last_ff  <= o_last_in;
      end
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_red        = o_red_ff;
   assign rsp_green      = o_green_ff;
   assign rsp_blue       = o_blue_ff;
   assign rsp_alpha      = o_alpha_ff;
   assign rsp_last_pixel = o_last_ff;

endmodule

// File: src/cpfc_yuv.sv
module cpfc_yuv import cpfc_pkg::*; (
   input  byte_type luma,
   input  byte_type chroma_u,
   input  byte_type chroma_v,
   output byte_type red,
   output byte_type green,
   output byte_type blue
);

   prod_type y_s;
   prod_type u_s;
   prod_type v_s;
   prod_type r_prod;
   prod_type g_prod;
   prod_type b_prod;
   prod_type r_sum;
   prod_type g_sum;
   prod_type b_sum;

   always_comb begin
      y_s = $signed(ProdWidth'(luma));
      u_s = $signed(ProdWidth'(chroma_u)) - CHROMA_OFFSET;
      v_s = $signed(ProdWidth'(chroma_v)) - CHROMA_OFFSET;
      r_prod = ProdWidth'(v_s * COEF_RV);
      g_prod = ProdWidth'(u_s * COEF_GU) + ProdWidth'(v_s * COEF_GV);
      b_prod = ProdWidth'(u_s * COEF_BU);
      // arithmetic shift floors towards minus infinity
      r_sum = y_s + (r_prod >>> 8);
      g_sum = y_s - (g_prod >>> 8);
      b_sum = y_s + (b_prod >>> 8);
   end

   assign red   = clamp_channel(r_sum);
   assign green = clamp_channel(g_sum);
   assign blue  = clamp_channel(b_sum);

endmodule
